FILE: rtl/mps_pkg.sv
// MIDI stream parser package: shared codes, item and config types.
// Used by every module of the parser; no dependencies of its own.
`default_nettype none

package mps_pkg;

  localparam int unsigned SYSEX_LEN_BITS_DEF = 13;
  localparam int unsigned SYSEX_MAX_W        = 13;
  localparam logic [SYSEX_MAX_W-1:0] SYSEX_MAX_RST = 13'd64;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_SYNC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_COMMON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSEX_MAX  = 2'd2;

  localparam int unsigned Q_DEPTH = 2;

  localparam logic [2:0] EV_MESSAGE     = 3'd0;
  localparam logic [2:0] EV_REALTIME    = 3'd1;
  localparam logic [2:0] EV_SYSEX_START = 3'd2;
  localparam logic [2:0] EV_SYSEX_DATA  = 3'd3;
  localparam logic [2:0] EV_SYSEX_END   = 3'd4;
  localparam logic [2:0] EV_SYSEX_ABORT = 3'd5;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_QFRAME   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_STOP     = 8'hFC;

  typedef enum logic [1:0] {
    ITEM_REALTIME,
    ITEM_DATA,
    ITEM_STATUS
  } item_cls_e;

  typedef struct packed {
    item_cls_e  cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic                   ext_sync;
    logic                   sys_common;
    logic [SYSEX_MAX_W-1:0] sysex_max;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/mps_front.sv
// Front end: config registers, byte intake and classification.
// Pushes classified bytes into the item queue; uses mps_pkg.
`default_nettype none

module mps_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mps_pkg::SYSEX_MAX_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output mps_pkg::item_t                    q_item_o,
  output mps_pkg::cfg_t                     cfg_o
);
  import mps_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic keep;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXT_SYNC:   cfg_d.ext_sync   = cfg_data_i[0];
        CFG_SYS_COMMON: cfg_d.sys_common = cfg_data_i[0];
        CFG_SYSEX_MAX:  cfg_d.sysex_max  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ext_sync   <= 1'b0;
      cfg_q.sys_common <= 1'b0;
      cfg_q.sysex_max  <= SYSEX_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Real-time bytes bypass the parse state; drop those that give no event.
  always_comb begin
    q_item_o.data = rx_byte_i;
    keep          = 1'b1;
    if (rx_byte_i[7:3] == 5'b11111) begin
      q_item_o.cls = ITEM_REALTIME;
      keep = cfg_q.ext_sync && (rx_byte_i == ST_START || rx_byte_i == ST_STOP);
    end else if (rx_byte_i[7]) begin
      q_item_o.cls = ITEM_STATUS;
    end else begin
      q_item_o.cls = ITEM_DATA;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

FILE: rtl/mps_queue.sv
// Short item queue between front and back end.
// Register-based FIFO of mps_pkg::item_t, depth mps_pkg::Q_DEPTH.
`default_nettype none

module mps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mps_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mps_pkg::item_t item_o
);
  import mps_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  item_t            mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mps_back.sv
// Back end: running-status parse state, SysEx tracking and result output.
// Pops items from mps_queue, drives the result channel; uses mps_pkg.
`default_nettype none

module mps_back #(
  parameter int unsigned SYSEX_LEN_BITS = mps_pkg::SYSEX_LEN_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mps_pkg::cfg_t             cfg_i,
  input  logic                      q_valid_i,
  input  mps_pkg::item_t            q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                event_kind_o,
  output logic [7:0]                status_byte_o,
  output logic [7:0]                first_data_o,
  output logic [7:0]                second_data_o,
  output logic [1:0]                data_count_o,
  output logic [SYSEX_LEN_BITS-1:0] sysex_position_o,
  output logic                      last_o
);
  import mps_pkg::*;

  localparam int unsigned CNT_W = SYSEX_LEN_BITS;
  localparam int unsigned CMP_W = (CNT_W > SYSEX_MAX_W) ? CNT_W : SYSEX_MAX_W;

  localparam logic [2:0] PH_IGNORE = 3'd0;
  localparam logic [2:0] PH_STATUS = 3'd1;
  localparam logic [2:0] PH_SYSEX  = 3'd2;
  localparam logic [2:0] PH_BYTE1  = 3'd3;
  localparam logic [2:0] PH_BYTE2  = 3'd4;

  localparam logic [3:0] VOICE_KINDS   = 4'd7;
  localparam logic [3:0] KIND_QFRAME   = 4'd7;
  localparam logic [3:0] KIND_SONG_POS = 4'd8;
  localparam logic [3:0] KIND_SONG_SEL = 4'd9;
  localparam logic [3:0] KIND_TUNE     = 4'd10;
  localparam logic [3:0] KIND_NONE     = 4'd11;

  typedef struct packed {
    logic [2:0]       phase;
    logic [7:0]       held;
    logic [2:0][7:0]  msg;
    logic [1:0]       fill;
    logic [3:0]       kind;
    logic [CNT_W-1:0] count;
    logic             aborted;
  } pstate_t;

  typedef struct packed {
    logic [2:0]       ev;
    logic [7:0]       status;
    logic [7:0]       d1;
    logic [7:0]       d2;
    logic [1:0]       cnt;
    logic [CNT_W-1:0] pos;
    logic             last;
  } res_t;

  typedef struct packed {
    pstate_t st;
    logic    again;
    logic    emit;
    res_t    res;
  } pass_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] need;
  } lookup_t;

  function automatic lookup_t lookup_f(logic [7:0] s);
    lookup_t r;
    r.kind = KIND_NONE;
    r.need = 2'd0;
    if (s[7] && s[7:4] != 4'hF) begin
      r.kind = {1'b0, s[6:4]};
      r.need = (s[6:4] == 3'd4 || s[6:4] == 3'd5) ? 2'd1 : 2'd2;
    end else begin
      unique case (s)
        ST_QFRAME:   begin r.kind = KIND_QFRAME;   r.need = 2'd1; end
        ST_SONG_POS: begin r.kind = KIND_SONG_POS; r.need = 2'd2; end
        ST_SONG_SEL: begin r.kind = KIND_SONG_SEL; r.need = 2'd1; end
        ST_TUNE:     begin r.kind = KIND_TUNE;     r.need = 2'd0; end
        default: ;
      endcase
    end
    return r;
  endfunction

  // One parse step on one byte; again asks for the byte to be parsed once more.
  function automatic pass_t step_f(pstate_t s, logic [7:0] b, cfg_t c);
    pass_t      p;
    lookup_t    lk;
    logic       run;
    logic       ok;
    logic [1:0] cnt;
    p       = '0;
    p.st    = s;
    lk      = '0;
    run     = 1'b0;
    ok      = 1'b1;
    cnt     = 2'd0;
    unique case (s.phase)
      PH_IGNORE: begin
        if (b[7]) begin
          p.st.phase = PH_STATUS;
          p.again    = 1'b1;
        end
      end
      PH_SYSEX: begin
        if (b[7]) begin
          p.st.phase = PH_STATUS;
          p.emit     = 1'b1;
          if (b != ST_EOX) begin
            p.st.count   = '0;
            p.st.aborted = 1'b1;
            p.res.ev     = EV_SYSEX_ABORT;
            p.again      = 1'b1;
          end else begin
            p.res.ev  = EV_SYSEX_END;
            p.res.pos = s.count;
          end
        end else if (!s.aborted) begin
          p.emit = 1'b1;
          if ((CMP_W'(s.count) < CMP_W'(c.sysex_max)) && (s.count != '1)) begin
            p.res.ev   = EV_SYSEX_DATA;
            p.res.d1   = b;
            p.res.pos  = s.count;
            p.st.count = s.count + 1'b1;
          end else begin
            p.st.count   = '0;
            p.st.aborted = 1'b1;
            p.res.ev     = EV_SYSEX_ABORT;
          end
        end
      end
      PH_STATUS: begin
        if (b == ST_SYSEX) begin
          p.st.phase   = PH_SYSEX;
          p.st.count   = '0;
          p.st.aborted = 1'b0;
          p.st.held    = '0;
          p.emit       = 1'b1;
          p.res.ev     = EV_SYSEX_START;
        end else begin
          if (b[7]) begin
            p.st.held = b;
          end else if (s.held == '0) begin
            ok = 1'b0;
          end else begin
            run = 1'b1;
          end
          if (ok) begin
            lk        = lookup_f(p.st.held);
            p.st.kind = lk.kind;
            if (lk.kind == KIND_NONE) begin
              p.st.phase = PH_IGNORE;
            end else begin
              p.st.msg[0] = p.st.held;
              p.st.fill   = 2'd1;
              p.st.phase  = (lk.need == 2'd2) ? PH_BYTE2 :
                            (lk.need == 2'd1) ? PH_BYTE1 : PH_STATUS;
              p.again     = run && (lk.need != 2'd0);
            end
          end
        end
      end
      PH_BYTE1: begin
        if (s.fill != 2'd3) begin
          p.st.msg[s.fill] = b;
          p.st.fill        = s.fill + 1'b1;
        end
        p.st.phase = PH_STATUS;
        if (s.kind < VOICE_KINDS || (c.sys_common && s.kind <= KIND_SONG_SEL)) begin
          cnt        = (p.st.fill != 2'd0) ? p.st.fill - 1'b1 : 2'd0;
          p.emit     = 1'b1;
          p.res.ev   = EV_MESSAGE;
          p.res.status = p.st.msg[0];
          p.res.d1   = p.st.msg[1];
          p.res.d2   = (cnt >= 2'd2) ? p.st.msg[2] : 8'd0;
          p.res.cnt  = cnt;
        end
      end
      PH_BYTE2: begin
        if (s.fill != 2'd3) begin
          p.st.msg[s.fill] = b;
          p.st.fill        = s.fill + 1'b1;
        end
        p.st.phase = PH_BYTE1;
      end
      default: begin
        p.st.phase = PH_IGNORE;
      end
    endcase
    return p;
  endfunction

  pstate_t st_q, st_d, st_next;
  pass_t   p0, p1;
  res_t    r0, r1, rt_res;
  res_t    out_q, out_d, pend_q, pend_d;
  logic    out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic    has0, has1, e1, out_free, pop;

  // Parse the head item: at most two chained steps, each with at most one result.
  always_comb begin
    p0      = step_f(st_q, q_item_i.data, cfg_i);
    p1      = step_f(p0.st, q_item_i.data, cfg_i);
    e1      = p0.again && p1.emit;
    rt_res        = '0;
    rt_res.ev     = EV_REALTIME;
    rt_res.status = q_item_i.data;
    unique case (q_item_i.cls)
      ITEM_REALTIME: begin
        st_next = st_q;
        has0    = 1'b1;
        has1    = 1'b0;
        r0      = rt_res;
      end
      ITEM_DATA, ITEM_STATUS: begin
        st_next = p0.again ? p1.st : p0.st;
        has0    = p0.emit || e1;
        has1    = p0.emit && e1;
        r0      = p0.emit ? p0.res : p1.res;
      end
      default: begin
        st_next = st_q;
        has0    = 1'b0;
        has1    = 1'b0;
        r0      = '0;
      end
    endcase
    r0.last = !has1;
    r1      = p1.res;
    r1.last = 1'b1;
  end

  // Hold a second result in pend until the output stage frees up.
  always_comb begin
    out_free     = !out_valid_q || out_ready_i;
    pop          = q_valid_i && !pend_valid_q && out_free;
    st_d         = pop ? st_next : st_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    priority if (pend_valid_q && out_free) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end else if (pop && has0) begin
      out_d       = r0;
      out_valid_d = 1'b1;
      if (has1) begin
        pend_d       = r1;
        pend_valid_d = 1'b1;
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      st_q         <= st_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign q_pop_o          = pop;
  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = out_q.ev;
  assign status_byte_o    = out_q.status;
  assign first_data_o     = out_q.d1;
  assign second_data_o    = out_q.d2;
  assign data_count_o     = out_q.cnt;
  assign sysex_position_o = out_q.pos;
  assign last_o           = out_q.last;

endmodule

`default_nettype wire

FILE: rtl/midi_stream_parser_top.sv
// MIDI byte-stream parser with running status and SysEx tracking.
// Input side: in_valid_i/in_ready_o beats carry one received byte (rx_byte_i).
// Output side: out_valid_o/out_ready_i beats carry one event each; last_o
// marks the final event caused by a byte. A SysEx interrupted by 0xF0 gives
// two events (abort, then start); every other byte gives zero or one.
// Config side: cfg_valid_i/cfg_ready_o writes cfg_data_i to register
// cfg_index_i (0 external sync, 1 system common delivery, 2 SysEx limit);
// cfg_ready_o is always high. Write config only while the parser is idle.
// An accepted byte is registered in the queue, then its event in the output
// register. Throughput: one byte per cycle while out_ready_i is high, but a
// byte with two events holds the back end while the second waits and can fill
// the two-entry queue between the classifying front end and parsing back end.
// Reset clears the parse state and config (SysEx limit 64); the parser then
// ignores data bytes until a status byte arrives.
// When the receiver stalls, the output register holds its event, the queue
// fills and in_ready_o drops once both queue entries are taken.
// Depends on mps_pkg, mps_front, mps_queue and mps_back.
`default_nettype none

module midi_stream_parser_top #(
  parameter int unsigned SYSEX_LEN_BITS = mps_pkg::SYSEX_LEN_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mps_pkg::SYSEX_MAX_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      event_kind_o,
  output logic [7:0]                      status_byte_o,
  output logic [7:0]                      first_data_o,
  output logic [7:0]                      second_data_o,
  output logic [1:0]                      data_count_o,
  output logic [SYSEX_LEN_BITS-1:0]       sysex_position_o,
  output logic                            last_o
);
  import mps_pkg::*;

  cfg_t  cfg;
  item_t push_item, head_item;
  logic  q_push, q_full, q_pop, q_valid;

  mps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item),
    .cfg_o       (cfg)
  );

  mps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  mps_back #(
    .SYSEX_LEN_BITS (SYSEX_LEN_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_valid_i        (q_valid),
    .q_item_i         (head_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_o     (event_kind_o),
    .status_byte_o    (status_byte_o),
    .first_data_o     (first_data_o),
    .second_data_o    (second_data_o),
    .data_count_o     (data_count_o),
    .sysex_position_o (sysex_position_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mps_checker.sv
// Port-level checks for midi_stream_parser_top, bound to the top level.
// Uses mps_pkg event and status codes.
`default_nettype none

module mps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_kind_o,
  input logic [7:0] status_byte_o,
  input logic [1:0] data_count_o,
  input logic       last_o
);
  import mps_pkg::*;

  // A stalled event beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(status_byte_o) && $stable(last_o))
    else $error("event changed while stalled");

  // Only a SysEx abort can be followed by another event from the same byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> event_kind_o == EV_SYSEX_ABORT)
    else $error("non-final event that is not an abort");

  // The second event of a byte comes in the very next beat and is SysEx start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && event_kind_o == EV_SYSEX_START && last_o)
    else $error("abort not followed by sysex start");

  // Real-time events are only Start and Stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_REALTIME |->
      status_byte_o == ST_START || status_byte_o == ST_STOP)
    else $error("unexpected real-time event");

  // Complete messages carry a status byte and one or two data bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_MESSAGE |->
      status_byte_o[7] && data_count_o != 2'd0 && data_count_o != 2'd3)
    else $error("malformed message event");

endmodule

bind midi_stream_parser_top mps_checker u_mps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_kind_o  (event_kind_o),
  .status_byte_o (status_byte_o),
  .data_count_o  (data_count_o),
  .last_o        (last_o)
);

`default_nettype wire
